// ----- rtl/core/abk_pkg.sv -----
`default_nettype none
package abk_pkg;
    localparam int DEF_WORD_WIDTH = 32;
    localparam int FIELD_W        = 32;
    localparam int CFG_IDX_W      = 2;
    localparam int FRAC_COV       = 24;
    localparam int OPND_W         = FIELD_W + 1;
    localparam int PROD_W         = 2 * OPND_W;
    localparam int ACC_W          = PROD_W + 2;
    localparam int DEN_W          = FIELD_W + 2;
    localparam int DIVD_W         = FIELD_W + FRAC_COV;
    localparam int QUO_W          = DIVD_W + 1;

    typedef logic signed [FIELD_W-1:0] t_word;
    typedef logic        [FIELD_W-1:0] t_uword;
    typedef logic signed [OPND_W-1:0]  t_opnd;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [DEN_W-1:0]   t_den;
    typedef logic signed [QUO_W-1:0]   t_quo;

    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_NOISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_NOISE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD      = 2'd3;

    localparam t_uword RST_ANGLE_NOISE = 32'd16777;
    localparam t_uword RST_BIAS_NOISE  = 32'd50332;
    localparam t_uword RST_MEAS_NOISE  = 32'd8388608;
    localparam t_uword RST_PERIOD      = 32'd167772;
    localparam t_word  COV_ONE         = 32'sd16777216;

    typedef struct packed {
        logic  start;
        t_word num;
        t_den  den;
    } t_div_req;
endpackage
`default_nettype wire

// ----- rtl/core/abk_in_if.sv -----
`default_nettype none
interface abk_in_if;
    import abk_pkg::*;
    logic  valid;
    logic  ready;
    t_word measured_angle;
    t_word gyro_rate;
    modport source (output valid, output measured_angle, output gyro_rate, input ready);
    modport sink   (input valid, input measured_angle, input gyro_rate, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/abk_out_if.sv -----
`default_nettype none
interface abk_out_if;
    import abk_pkg::*;
    logic  valid;
    logic  ready;
    t_word angle_estimate;
    t_word rate_estimate;
    modport source (output valid, output angle_estimate, output rate_estimate, input ready);
    modport sink   (input valid, input angle_estimate, input rate_estimate, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/angle_bias_kalman_filter_unit.sv -----
`default_nettype none
// Angle / gyro-bias Kalman filter, two states, signed fixed point.
//
// Input channel i_in carries one IMU sample per request: measured_angle and
// gyro_rate, both signed Q16.16. Output channel o_out carries one result per
// sample: angle_estimate and rate_estimate (gyro rate minus new bias), Q16.16,
// saturated to WORD_WIDTH bits (clamped to 16..32).
// Configuration is a plain write port: i_cfg_we, i_cfg_idx, i_cfg_data; the
// four noise/period registers are unsigned Q8.24. Write only while idle.
//
// One request runs a prep step, 11 products through the one shared
// multiplier (issue, then round and accumulate), an innovation step and
// two gain divisions on the shared radix-2 divider, which end early when
// the innovation variance is zero, plus the result step. i_in.ready is
// high only in the idle state, so a new sample is taken only once the
// previous one has reached the result register.
//
// Reset (synchronous, active low) restores the register defaults, zeroes
// angle and bias, and sets the covariance to identity. The result register
// holds its value while o_out.ready is low; a new request may be accepted
// meanwhile and its processing stalls at the end until the old result leaves.
module angle_bias_kalman_filter_unit #(
    parameter int WORD_WIDTH = abk_pkg::DEF_WORD_WIDTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [abk_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [abk_pkg::FIELD_W-1:0]   i_cfg_data,
    abk_in_if.sink                             i_in,
    abk_out_if.source                          o_out
);
    import abk_pkg::*;

    localparam int EFF_W = (WORD_WIDTH > FIELD_W) ? FIELD_W :
                           ((WORD_WIDTH < 16) ? 16 : WORD_WIDTH);
    localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) <<< (EFF_W - 1)) - 1;
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - 1;
    localparam logic signed [ACC_W-1:0] RND    = ACC_W'(1) <<< (FRAC_COV - 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_PREP, ST_MUL, ST_ACC, ST_ERR,
        ST_DIV0, ST_DIV0W, ST_DIV1, ST_DIV1W, ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        DST_ANG, DST_BIAS, DST_P00, DST_P01, DST_P10, DST_P11
    } t_dst;

    localparam logic [3:0] STEP_LAST_PRED = 4'd4;
    localparam logic [3:0] STEP_LAST      = 4'd10;

    function automatic t_word sat_w(input logic signed [ACC_W-1:0] v);
        if (v > SAT_HI) return t_word'(SAT_HI);
        if (v < SAT_LO) return t_word'(SAT_LO);
        return t_word'(v);
    endfunction

    t_state r_state;
    logic [3:0] r_step;
    t_uword r_apn, r_bpn, r_mn, r_dt;
    t_word  r_ang, r_bias, r_p00, r_p01, r_p10, r_p11;
    t_word  r_meas, r_gyro, r_rate, r_d0, r_d1, r_d3;
    t_word  r_k0, r_k1, r_t0, r_t1, r_err;
    t_den   r_e;
    logic   r_ovalid;
    t_word  r_oang, r_orate;

    t_opnd  n_a, n_b;
    t_dst   n_dst;
    logic   n_sub;
    t_word  n_base;
    logic signed [ACC_W-1:0] n_scaled, n_acc;
    t_word  n_res;
    t_prod  w_p;
    t_div_req n_req;
    logic   w_done;
    t_quo   w_quo;

    // operand / destination select per step
    always_comb begin
        n_a   = '0;
        n_b   = t_opnd'(r_dt);
        n_dst = DST_ANG;
        n_sub = 1'b0;
        case (r_step)
            4'd0:    begin n_a = t_opnd'(r_rate); n_dst = DST_ANG; end
            4'd1:    begin n_a = t_opnd'(r_d0);   n_dst = DST_P00; end
            4'd2:    begin n_a = t_opnd'(r_d1);   n_dst = DST_P01; end
            4'd3:    begin n_a = t_opnd'(r_d1);   n_dst = DST_P10; end
            4'd4:    begin n_a = t_opnd'(r_d3);   n_dst = DST_P11; end
            4'd5:    begin n_a = t_opnd'(r_k0); n_b = t_opnd'(r_t0);  n_dst = DST_P00;
                           n_sub = 1'b1; end
            4'd6:    begin n_a = t_opnd'(r_k0); n_b = t_opnd'(r_t1);  n_dst = DST_P01;
                           n_sub = 1'b1; end
            4'd7:    begin n_a = t_opnd'(r_k1); n_b = t_opnd'(r_t0);  n_dst = DST_P10;
                           n_sub = 1'b1; end
            4'd8:    begin n_a = t_opnd'(r_k1); n_b = t_opnd'(r_t1);  n_dst = DST_P11;
                           n_sub = 1'b1; end
            4'd9:    begin n_a = t_opnd'(r_k0); n_b = t_opnd'(r_err); n_dst = DST_ANG; end
            4'd10:   begin n_a = t_opnd'(r_k1); n_b = t_opnd'(r_err); n_dst = DST_BIAS; end
            default: begin n_a = '0; end
        endcase
        case (n_dst)
            DST_ANG:  n_base = r_ang;
            DST_BIAS: n_base = r_bias;
            DST_P00:  n_base = r_p00;
            DST_P01:  n_base = r_p01;
            DST_P10:  n_base = r_p10;
            DST_P11:  n_base = r_p11;
            default:  n_base = r_ang;
        endcase
        // round to nearest, ties up: floor((p + 2^23) / 2^24)
        n_scaled = (ACC_W'(w_p) + RND) >>> FRAC_COV;
        n_acc    = n_sub ? ACC_W'(n_base) - n_scaled : ACC_W'(n_base) + n_scaled;
        n_res    = sat_w(n_acc);
        n_req.start = (r_state == ST_DIV0) || (r_state == ST_DIV1);
        n_req.num   = (r_state == ST_DIV1) ? r_p10 : r_p00;
        n_req.den   = r_e;
    end

    abk_mul u_mul (
        .i_clk (i_clk),
        .i_en  (r_state == ST_MUL),
        .i_a   (n_a),
        .i_b   (n_b),
        .o_p   (w_p)
    );

    abk_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_req),
        .o_done  (w_done),
        .o_quo   (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= '0;
            r_ovalid <= 1'b0;
            r_apn    <= RST_ANGLE_NOISE;
            r_bpn    <= RST_BIAS_NOISE;
            r_mn     <= RST_MEAS_NOISE;
            r_dt     <= RST_PERIOD;
            r_ang    <= '0;
            r_bias   <= '0;
            r_p00    <= COV_ONE;
            r_p01    <= '0;
            r_p10    <= '0;
            r_p11    <= COV_ONE;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ANGLE_NOISE: r_apn <= i_cfg_data;
                    REG_BIAS_NOISE:  r_bpn <= i_cfg_data;
                    REG_MEAS_NOISE:  r_mn  <= i_cfg_data;
                    REG_PERIOD:      r_dt  <= i_cfg_data;
                    default:         r_dt  <= r_dt;
                endcase
            end
            // result leaves; ST_OUT reloads the register itself
            if (r_ovalid && o_out.ready && (r_state != ST_OUT)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_meas  <= i_in.measured_angle;
                        r_gyro  <= i_in.gyro_rate;
                        r_state <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    r_rate  <= sat_w(ACC_W'(r_gyro) - ACC_W'(r_bias));
                    r_d0    <= sat_w(ACC_W'({1'b0, r_apn}) - ACC_W'(r_p01) - ACC_W'(r_p10));
                    r_d1    <= sat_w(-ACC_W'(r_p11));
                    r_d3    <= sat_w(ACC_W'({1'b0, r_bpn}));
                    r_step  <= '0;
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    case (n_dst)
                        DST_ANG:  r_ang  <= n_res;
                        DST_BIAS: r_bias <= n_res;
                        DST_P00:  r_p00  <= n_res;
                        DST_P01:  r_p01  <= n_res;
                        DST_P10:  r_p10  <= n_res;
                        DST_P11:  r_p11  <= n_res;
                        default:  r_ang  <= r_ang;
                    endcase
                    r_step <= r_step + 4'd1;
                    if (r_step == STEP_LAST_PRED) begin
                        r_state <= ST_ERR;
                    end else if (r_step == STEP_LAST) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_state <= ST_MUL;
                    end
                end
                ST_ERR: begin
                    r_err   <= sat_w(ACC_W'(r_meas) - ACC_W'(r_ang));
                    r_e     <= t_den'({2'b00, r_mn}) + t_den'(r_p00);
                    r_t0    <= r_p00;
                    r_t1    <= r_p01;
                    r_state <= ST_DIV0;
                end
                ST_DIV0: begin
                    r_state <= ST_DIV0W;
                end
                ST_DIV0W: begin
                    if (w_done) begin
                        r_k0    <= sat_w(ACC_W'(w_quo));
                        r_state <= ST_DIV1;
                    end
                end
                ST_DIV1: begin
                    r_state <= ST_DIV1W;
                end
                ST_DIV1W: begin
                    if (w_done) begin
                        r_k1    <= sat_w(ACC_W'(w_quo));
                        r_state <= ST_MUL;
                    end
                end
                ST_OUT: begin
                    // wait for the result register to drain
                    if (!r_ovalid || o_out.ready) begin
                        r_oang   <= r_ang;
                        r_orate  <= sat_w(ACC_W'(r_gyro) - ACC_W'(r_bias));
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign i_in.ready           = (r_state == ST_IDLE);
    assign o_out.valid          = r_ovalid;
    assign o_out.angle_estimate = r_oang;
    assign o_out.rate_estimate  = r_orate;
endmodule
`default_nettype wire

// ----- rtl/core/abk_mul.sv -----
`default_nettype none
module abk_mul (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire abk_pkg::t_opnd i_a,
    input  wire abk_pkg::t_opnd i_b,
    output abk_pkg::t_prod      o_p
);
    import abk_pkg::*;
    t_prod r_p;

    // exact signed product, registered
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;
endmodule
`default_nettype wire

// ----- rtl/core/abk_div.sv -----
`default_nettype none
module abk_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire abk_pkg::t_div_req i_req,
    output logic                   o_done,
    output abk_pkg::t_quo          o_quo
);
    import abk_pkg::*;
    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic               r_busy;
    logic               r_done;
    logic               r_neg;
    logic [CNT_W-1:0]   r_cnt;
    logic [DIVD_W-1:0]  r_quo;
    logic [DEN_W-1:0]   r_rem;
    logic [DEN_W-1:0]   r_dsr;
    logic [DEN_W:0]     n_trial;
    logic [DEN_W:0]     n_diff;
    logic               n_ge;
    logic [FIELD_W-1:0] n_num_mag;
    logic [DEN_W-1:0]   n_den_mag;
    logic [QUO_W-1:0]   n_mag;

    always_comb begin
        n_trial   = {r_rem, r_quo[DIVD_W-1]};
        n_diff    = n_trial - {1'b0, r_dsr};
        n_ge      = (n_trial >= {1'b0, r_dsr});
        n_num_mag = i_req.num[FIELD_W-1] ? FIELD_W'(-i_req.num) : FIELD_W'(i_req.num);
        n_den_mag = i_req.den[DEN_W-1] ? DEN_W'(-i_req.den) : DEN_W'(i_req.den);
        n_mag     = {1'b0, r_quo};
    end

    // restoring division on magnitudes, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= (i_req.start && (i_req.den == '0)) ||
                      (!i_req.start && r_busy && (r_cnt == CNT_W'(1)));
            if (i_req.start) begin
                r_neg <= i_req.num[FIELD_W-1] ^ i_req.den[DEN_W-1];
                r_rem <= '0;
                r_dsr <= n_den_mag;
                if (i_req.den == '0) begin
                    r_quo  <= '0;
                end else begin
                    r_quo  <= {n_num_mag, {FRAC_COV{1'b0}}};
                    r_cnt  <= CNT_W'(DIVD_W);
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= n_ge ? n_diff[DEN_W-1:0] : n_trial[DEN_W-1:0];
                r_quo <= {r_quo[DIVD_W-2:0], n_ge};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? t_quo'(-n_mag) : t_quo'(n_mag);
endmodule
`default_nettype wire

// ----- rtl/core/abk_checker.sv -----
`default_nettype none
module abk_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        i_in_ready,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [abk_pkg::FIELD_W-1:0] i_out_angle,
    input wire logic [abk_pkg::FIELD_W-1:0] i_out_rate
);
    // busy right after a request is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after accept");

    // reset leaves idle and empty
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && i_in_ready))
        else $error("bad state after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_angle) && $stable(i_out_rate)))
        else $error("stalled result changed");

    // a result only appears at the end of a request's processing, never while idle-ready
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid && i_in_ready && !i_in_valid) |=> !i_out_valid)
        else $error("result without request");
endmodule

bind angle_bias_kalman_filter_unit abk_checker u_abk_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_angle (o_out.angle_estimate),
    .i_out_rate  (o_out.rate_estimate)
);
`default_nettype wire
